/* src/blowfish_block_encrypt_assert.svh */
// Assertion macros for the Blowfish encryptor top module.
`ifndef BLOWFISH_BLOCK_ENCRYPT_ASSERT_SVH
`define BLOWFISH_BLOCK_ENCRYPT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("blowfish_block_encrypt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BFE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("blowfish_block_encrypt: next-cycle check failed");

`endif

/* src/bfe_pkg.sv */
package bfe_pkg;

   localparam int ROUNDS     = 16;
   localparam int PWORDS     = 18;
   localparam int SBOXES     = 4;
   localparam int SBOX_DEPTH = 256;

   localparam int WORD_W     = 32;
   localparam int BLOCK_W    = 64;
   localparam int IDX_W      = 10;
   localparam int OP_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int SBOX_SEL_W = $clog2(SBOXES);
   localparam int KEY_AW     = $clog2(PWORDS);
   localparam int ROUND_W    = $clog2(ROUNDS);

   // Operation codes of an input transfer.
   localparam logic [OP_W-1:0] OP_SUBKEY  = 2'd0;
   localparam logic [OP_W-1:0] OP_SBOX    = 2'd1;
   localparam logic [OP_W-1:0] OP_ENCRYPT = 2'd2;

   // Fixed subkey addresses used by the sequencer.
   localparam logic [KEY_AW-1:0] KEY_FIRST   = KEY_AW'(0);
   localparam logic [KEY_AW-1:0] KEY_SECOND  = KEY_AW'(1);
   localparam logic [KEY_AW-1:0] KEY_LAST    = KEY_AW'(PWORDS - 1);
   localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

   // One table write, decoded from a load transfer.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] index;
      logic [WORD_W-1:0] word;
   } bfe_wr_type;

endpackage

/* src/bfe_ram.sv */
module bfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/bfe_sbox_bank.sv */
module bfe_sbox_bank
   import bfe_pkg::*;
(
   input  logic              clock,
   input  bfe_wr_type        wr,
   input  logic [WORD_W-1:0] rd_x,
   output logic [WORD_W-1:0] f_value
);

   logic [WORD_W-1:0] s_data [SBOXES];

   // Box k is addressed by byte k of the word, counting from the top byte.
   for (genvar k = 0; k < SBOXES; k++) begin : g_box
      logic                     box_wr_en;
      logic [BYTE_W-1:0]        box_rd_addr;

      assign box_wr_en   = wr.en && (wr.index[IDX_W-1 -: SBOX_SEL_W] == SBOX_SEL_W'(k));
      assign box_rd_addr = rd_x[WORD_W-1-k*BYTE_W -: BYTE_W];

      bfe_ram #(
         .WIDTH(WORD_W),
         .DEPTH(SBOX_DEPTH)
      ) u_box (
         .clock  (clock),
         .wr_en  (box_wr_en),
         .wr_addr(wr.index[BYTE_W-1:0]),
         .wr_data(wr.word),
         .rd_addr(box_rd_addr),
         .rd_data(s_data[k])
      );
   end

   // F(x) = ((S0 + S1) ^ S2) + S3 on the words read in the previous cycle.
   assign f_value = ((s_data[0] + s_data[1]) ^ s_data[2]) + s_data[3];

endmodule

/* src/blowfish_block_encrypt.sv */
// Blowfish block encryptor with a loadable expanded key.
//
// The input channel (req_*) carries three kinds of transfer. A subkey load
// writes one of the 18 P-array words, an S-box load writes one of the 1024
// S-box words (box number in the top two index bits), and an encrypt transfer
// starts the encryption of one 64-bit block. Loads produce no result; each
// encrypt produces exactly one transfer on the result channel (rsp_*).
// Every table entry must be loaded before an encrypt reads it.
//
// A load completes in the cycle it is accepted. For an encrypt, P[0] is
// fetched during the accepting cycle itself, the key state applies it, the
// round state runs the 16 Feistel rounds through the loop of the four S-box
// RAMs and the F adders, and the done state does the final whitening. A new
// transfer is accepted only while the sequencer is idle, so the block takes no
// new transfer until the last block has left the sequencer. The result sits in an
// output register, so the next transfer can be accepted while it waits; if the
// receiver stalls and a second result is ready, the sequencer holds in its
// final state until the register frees. Synchronous reset empties the output
// register and idles the sequencer; the key tables are not cleared.
`include "blowfish_block_encrypt_assert.svh"

module blowfish_block_encrypt
   import bfe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_op,
   input  logic [IDX_W-1:0]   req_table_index,
   input  logic [WORD_W-1:0]  req_table_word,
   input  logic [BLOCK_W-1:0] req_plain_block,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BLOCK_W-1:0] rsp_cipher_block
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_KEY   = 4'b0010,
      ST_ROUND = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [WORD_W-1:0]  left_ff, left_in;
   logic [WORD_W-1:0]  right_ff, right_in;
   logic               out_valid_ff, out_valid_in;
   logic [BLOCK_W-1:0] cipher_ff, cipher_in;

   logic               req_accept;
   logic               out_load;
   bfe_wr_type         key_wr;
   bfe_wr_type         sbox_wr;
   logic [KEY_AW-1:0]  key_rd_addr;
   logic [WORD_W-1:0]  key_rd_data;
   logic [WORD_W-1:0]  sbox_x;
   logic [WORD_W-1:0]  f_value;
   logic [WORD_W-1:0]  new_right;
   logic [WORD_W-1:0]  next_x;

   // Transfers are taken only while the sequencer is idle.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Load transfers write the tables in the cycle they are accepted. A subkey
   // index past the end of the P-array is dropped.
   assign key_wr.en     = req_accept && (req_op == OP_SUBKEY)
                          && (req_table_index < IDX_W'(PWORDS));
   assign key_wr.index  = req_table_index;
   assign key_wr.word   = req_table_word;
   assign sbox_wr.en    = req_accept && (req_op == OP_SBOX);
   assign sbox_wr.index = req_table_index;
   assign sbox_wr.word  = req_table_word;

   // The subkey read address runs one step ahead of its use, because the
   // RAM read data is registered.
   always_comb begin
      case (state_ff)
         ST_IDLE:  key_rd_addr = KEY_FIRST;
         ST_KEY:   key_rd_addr = KEY_SECOND;
         ST_ROUND: key_rd_addr = KEY_AW'({1'b0, round_ff}) + KEY_AW'(2);
         ST_DONE:  key_rd_addr = KEY_LAST;
         default:  key_rd_addr = KEY_FIRST;
      endcase
   end

   bfe_ram #(
      .WIDTH(WORD_W),
      .DEPTH(PWORDS)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (key_wr.en),
      .wr_addr(key_wr.index[KEY_AW-1:0]),
      .wr_data(key_wr.word),
      .rd_addr(key_rd_addr),
      .rd_data(key_rd_data)
   );

   // In a round the S-box words for the current left half arrive, F is formed
   // and folded into the right half, and that result XOR the next subkey is
   // the left half of the following round, which addresses the S-boxes at once.
   assign new_right = right_ff ^ f_value;
   assign next_x    = new_right ^ key_rd_data;
   assign sbox_x    = (state_ff == ST_KEY) ? (left_ff ^ key_rd_data) : next_x;

   bfe_sbox_bank u_sbox_bank (
      .clock  (clock),
      .wr     (sbox_wr),
      .rd_x   (sbox_x),
      .f_value(f_value)
   );

   // The output register can be loaded when it is empty or being taken.
   assign out_load = (state_ff == ST_DONE) && (!out_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      cipher_in    = cipher_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_op == OP_ENCRYPT)) begin
               left_in  = req_plain_block[BLOCK_W-1:WORD_W];
               right_in = req_plain_block[WORD_W-1:0];
               state_in = ST_KEY;
            end
         end
         ST_KEY: begin
            left_in  = sbox_x;
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == ROUND_LAST) begin
               // The last round does not swap; P[16] whitens the right half.
               right_in = next_x;
               state_in = ST_DONE;
            end else begin
               left_in  = next_x;
               right_in = left_ff;
               round_in = round_ff + ROUND_W'(1);
            end
         end
         ST_DONE: begin
            if (out_load) begin
               cipher_in    = {left_ff ^ key_rd_data, right_ff};
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         out_valid_ff <= out_valid_in;
      end
      left_ff   <= left_in;
      right_ff  <= right_in;
      cipher_ff <= cipher_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_cipher_block = cipher_ff;

   // A result appears only after the whitening cycle.
   `BFE_ASSERT_SAME(a_result_from_done, $rose(rsp_valid), $past(state_ff == ST_DONE))
   // Applying P[0] always starts the round loop at round zero.
   `BFE_ASSERT_NEXT(a_key_starts_rounds, state_ff == ST_KEY,
                    (state_ff == ST_ROUND) && (round_ff == '0))
   // The loop leaves only after the last round.
   `BFE_ASSERT_NEXT(a_rounds_complete, (state_ff == ST_ROUND) && (round_ff != ROUND_LAST),
                    state_ff == ST_ROUND)
   // A finished block waits while an earlier result is still stalled.
   `BFE_ASSERT_NEXT(a_done_holds, (state_ff == ST_DONE) && rsp_valid && rsp_stall,
                    state_ff == ST_DONE)

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

// Block-level bench for the Blowfish encryptor.
//
// The bench first fills the whole expanded key with zeros. It then walks a short table of
// transfers; the first ciphertexts can be worked out by hand, because an all-zero key only swaps
// the halves. After that it sends a long random mix of table loads and encrypts, so random
// words steadily replace the zero key. A local model of the P-array and the S-boxes follows
// every accepted load, so every encrypt after the first fill reads entries that were written.
// Both channels idle and stall at random. A few times the receiver holds off long enough for
// the block to fill up and stall its input.
module tb;
   import bfe_pkg::*;

   // The fourth op code is not defined by the block and must be dropped.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int SWORDS = SBOXES * SBOX_DEPTH;
   localparam int RANDOM_ITEMS = 510;
   localparam int DRAIN_CYCLES = 40;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [OP_W-1:0]    req_op;
   logic [IDX_W-1:0]   req_table_index;
   logic [WORD_W-1:0]  req_table_word;
   logic [BLOCK_W-1:0] req_plain_block;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [BLOCK_W-1:0] rsp_cipher_block;

   blowfish_block_encrypt i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_table_index  (req_table_index),
      .req_table_word   (req_table_word),
      .req_plain_block  (req_plain_block),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cipher_block (rsp_cipher_block)
   );

   // The bench's own copy of the expanded key. It is updated when a load transfer is
   // accepted, so it always matches what the block holds at that point.
   logic [WORD_W-1:0]  subkey_mem [PWORDS];
   logic [WORD_W-1:0]  sbox_mem [SWORDS];

   // Ciphertexts that are still owed by the block, oldest first.
   logic [BLOCK_W-1:0] cipher_expect [$];
   logic [BLOCK_W-1:0] cipher_want;
   int unsigned        ciphers_seen;
   int unsigned        mismatch_count;
   int unsigned        send_calm;

   // One row of the opening table. When pinned is set, the ciphertext is given in the row
   // itself. Otherwise it comes from the local model.
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [IDX_W-1:0]   index;
      logic [WORD_W-1:0]  word;
      logic [BLOCK_W-1:0] plain;
      logic               pinned;
      logic [BLOCK_W-1:0] cipher;
   } probe_row_type;

   // The key is all zero when this table starts. With a zero key the F function is zero, and
   // the fifteen swaps leave the halves exchanged. Writes that should be dropped come before
   // the block that would reveal them. The later rows bring in nonzero subkeys, entry 0 of
   // each S-box and the last entry of the fourth S-box.
   probe_row_type opening_rows [25] = '{
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'h0,                1'b1, 64'h0},
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'hffffffffffffffff, 1'b1, 64'hffffffffffffffff},
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'h0123456789abcdef, 1'b1, 64'h89abcdef01234567},
      '{OP_SUBKEY,  10'd18,   32'hffffffff, 64'h0,                1'b0, 64'h0},
      '{OP_SUBKEY,  10'd1023, 32'hffffffff, 64'h0,                1'b0, 64'h0},
      '{OP_UNUSED,  10'd1023, 32'hffffffff, 64'hffffffffffffffff, 1'b0, 64'h0},
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'hffffffff00000000, 1'b1, 64'h00000000ffffffff},
      '{OP_SUBKEY,  10'd17,   32'hffffffff, 64'h0,                1'b0, 64'h0},
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'h0,                1'b1, 64'hffffffff00000000},
      '{OP_SUBKEY,  10'd16,   32'hffffffff, 64'h0,                1'b0, 64'h0},
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'h0,                1'b1, 64'hffffffffffffffff},
      '{OP_SUBKEY,  10'd0,    32'h80000001, 64'h0,                1'b0, 64'h0},
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'h0,                1'b0, 64'h0},
      '{OP_SBOX,    10'd0,    32'hffffffff, 64'h0,                1'b0, 64'h0},
      '{OP_SBOX,    10'd1023, 32'hffffffff, 64'h0,                1'b0, 64'h0},
      '{OP_SBOX,    10'd512,  32'h00000001, 64'h0,                1'b0, 64'h0},
      '{OP_SBOX,    10'd256,  32'h12345678, 64'h0,                1'b0, 64'h0},
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'h0,                1'b0, 64'h0},
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'hffffffffffffffff, 1'b0, 64'h0},
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'h00000000ffffffff, 1'b0, 64'h0},
      '{OP_SUBKEY,  10'd0,    32'h00000000, 64'h0,                1'b0, 64'h0},
      '{OP_SUBKEY,  10'd16,   32'h00000000, 64'h0,                1'b0, 64'h0},
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'hfedcba9876543210, 1'b0, 64'h0},
      '{OP_SBOX,    10'd768,  32'hffffffff, 64'h0,                1'b0, 64'h0},
      '{OP_ENCRYPT, 10'd0,    32'h0,        64'hff00ff00ff00ff00, 1'b0, 64'h0}
   };

   // The clock period is 12 ns.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // This is the F function, built from the four S-boxes: add, xor, add.
   function automatic logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] acc;
      acc = sbox_mem[{2'd0, x[31:24]}] + sbox_mem[{2'd1, x[23:16]}];
      acc = acc ^ sbox_mem[{2'd2, x[15:8]}];
      acc = acc + sbox_mem[{2'd3, x[7:0]}];
      return acc;
   endfunction

   // This runs sixteen Feistel rounds and the two closing whitenings. The halves are not
   // swapped after the last round.
   function automatic logic [BLOCK_W-1:0] cipher_of(input logic [BLOCK_W-1:0] plain);
      logic [WORD_W-1:0] lh;
      logic [WORD_W-1:0] rh;
      logic [WORD_W-1:0] held;
      lh = plain[63:32];
      rh = plain[31:0];
      for (int k = 0; k < ROUNDS; k++) begin
         lh = lh ^ subkey_mem[k];
         rh = rh ^ round_mix(lh);
         if (k < ROUNDS - 1) begin
            held = lh;
            lh = rh;
            rh = held;
         end
      end
      rh = rh ^ subkey_mem[ROUNDS];
      lh = lh ^ subkey_mem[ROUNDS + 1];
      return {lh, rh};
   endfunction

   // Gaps are mostly absent or short, with an occasional long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Key words are mostly random. A few are all zeros or all ones.
   function automatic logic [WORD_W-1:0] key_word();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom;
   endfunction

   // This task offers one transfer after a random gap and waits until it is accepted. It then
   // updates the local key copy or queues the ciphertext that the transfer will produce.
   // Inputs change only at falling edges. req_stall is sampled at the rising edge.
   task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] index,
                        input logic [WORD_W-1:0] word, input logic [BLOCK_W-1:0] plain,
                        input logic pinned, input logic [BLOCK_W-1:0] pinned_cipher);
      int unsigned gap;
      if (send_calm > 0) begin
         send_calm--;
         gap = 0;
      end else if ($urandom_range(0, 7) == 0) begin
         // This starts a stretch of back-to-back transfers.
         send_calm = $urandom_range(20, 60);
         gap = 0;
      end else begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_op          <= op;
      req_table_index <= index;
      req_table_word  <= word;
      req_plain_block <= plain;
      do @(posedge clock); while (req_stall);
      case (op)
         OP_SUBKEY: begin
            // Subkey writes past the last P word are dropped by the block.
            if (index < PWORDS) subkey_mem[index] = word;
         end
         OP_SBOX: begin
            sbox_mem[index] = word;
         end
         OP_ENCRYPT: begin
            cipher_expect.push_back(pinned ? pinned_cipher : cipher_of(plain));
         end
         default: begin
         end
      endcase
   endtask

   // This writes every P word and every S-box word in order. It fills with zeros, or with
   // random words when scrambled is set. The fields that the loads do not use carry random
   // values.
   task automatic load_key(input logic scrambled);
      for (int k = 0; k < PWORDS; k++) begin
         issue(OP_SUBKEY, IDX_W'(k), scrambled ? key_word() : WORD_W'(0),
               {$urandom, $urandom}, 1'b0, '0);
      end
      for (int k = 0; k < SWORDS; k++) begin
         issue(OP_SBOX, IDX_W'(k), scrambled ? key_word() : WORD_W'(0),
               {$urandom, $urandom}, 1'b0, '0);
      end
   endtask

   // This is the stimulus: reset, zero key, opening table, then the random mix.
   initial begin : stimulus
      int unsigned counted;
      int unsigned pick;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_SUBKEY;
      req_table_index = '0;
      req_table_word  = '0;
      req_plain_block = '0;
      send_calm       = 0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // No encrypt is sent until every table entry has been written.
      load_key(1'b0);
      foreach (opening_rows[n]) begin
         issue(opening_rows[n].op, opening_rows[n].index, opening_rows[n].word,
               opening_rows[n].plain, opening_rows[n].pinned, opening_rows[n].cipher);
      end

      // Single words are rewritten between encrypts, so the key keeps changing under the
      // traffic and fills up with random words.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            issue(OP_ENCRYPT, IDX_W'($urandom), $urandom, {$urandom, $urandom}, 1'b0, '0);
            counted++;
         end else if (pick < 75) begin
            issue(OP_SBOX, IDX_W'($urandom), key_word(), {$urandom, $urandom}, 1'b0, '0);
            counted++;
         end else if (pick < 87) begin
            issue(OP_SUBKEY, IDX_W'($urandom_range(0, PWORDS - 1)), key_word(),
                  {$urandom, $urandom}, 1'b0, '0);
            counted++;
         end else if (pick < 93) begin
            // The block drops this subkey write because the index is out of range.
            issue(OP_SUBKEY, IDX_W'($urandom_range(PWORDS, (1 << IDX_W) - 1)), $urandom,
                  {$urandom, $urandom}, 1'b0, '0);
         end else begin
            issue(OP_UNUSED, IDX_W'($urandom), $urandom, {$urandom, $urandom}, 1'b0, '0);
         end
      end
      @(negedge clock) req_valid <= 1'b0;

      // Wait for the last ciphertext. Then keep watching the result channel in case a stray
      // transfer comes out.
      while (cipher_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("blowfish_block_encrypt test passed");
      end else begin
         $display("blowfish_block_encrypt test failed");
      end
      $finish;
   end

   // The receiver stalls at random and sometimes stays open for a whole stretch. After a set
   // number of ciphertexts it holds off for a long time. The output register and the
   // sequencer then fill up, and the block has to stall its input while the sender keeps
   // offering transfers.
   initial begin : result_side
      int unsigned hold_left;
      int unsigned calm_left;
      int unsigned next_squeeze;
      hold_left    = 0;
      calm_left    = 0;
      next_squeeze = 30;
      rsp_stall    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && calm_left == 0) begin
            if (ciphers_seen >= next_squeeze) begin
               hold_left    = 300;
               next_squeeze = next_squeeze + 120;
            end else if ($urandom_range(0, 5) == 0) begin
               calm_left = $urandom_range(20, 80);
            end else begin
               hold_left = pick_gap();
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (calm_left > 0) calm_left--;
         end
      end
   end

   // Each result transfer is checked against the oldest ciphertext that is still owed.
   initial begin
      ciphers_seen   = 0;
      mismatch_count = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cipher_expect.size() == 0) begin
            $error("cipher_block: no transfer expected, actual %h", rsp_cipher_block);
            mismatch_count++;
         end else begin
            cipher_want = cipher_expect.pop_front();
            if (rsp_cipher_block !== cipher_want) begin
               $error("cipher_block: expected %h, actual %h", cipher_want, rsp_cipher_block);
               mismatch_count++;
            end
         end
         ciphers_seen++;
      end
   end

   // This ends a run that hangs. The limit is far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("blowfish_block_encrypt test failed");
      $finish;
   end

endmodule
